// ----- sv/cdv_pkg.sv -----
// Shared types, constants and helper functions for the CPF check digit validator.
// Used by cdv_core and cpf_check_digit_validator; depends on nothing else.
package cdv_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
    } out_word_t;

    // Running sums are kept as residues mod 11.
    typedef struct packed {
        logic [3:0] char_count;
        logic [3:0] first_rem;
        logic [3:0] second_rem;
        logic [3:0] first_digit;
        logic [3:0] tenth_digit;
        logic       all_same;
        logic       saw_non_digit;
    } state_t;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_LENGTH    = 3'd1;
    localparam logic [2:0] ERR_NON_DIGIT = 3'd2;
    localparam logic [2:0] ERR_ALL_EQUAL = 3'd3;
    localparam logic [2:0] ERR_FIRST     = 3'd4;
    localparam logic [2:0] ERR_SECOND    = 3'd5;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [3:0] NUM_LENGTH  = 4'd11;
    localparam logic [3:0] COUNT_MAX   = 4'd12;
    localparam logic [3:0] FIRST_SPAN  = 4'd9;
    localparam logic [3:0] SECOND_SPAN = 4'd10;
    localparam logic [3:0] FIRST_TOP   = 4'd10;
    localparam logic [3:0] SECOND_TOP  = 4'd11;
    localparam logic [3:0] TENTH_IDX   = 4'd9;

    localparam state_t STATE_RESET = '{
        char_count:    4'd0,
        first_rem:     4'd0,
        second_rem:    4'd0,
        first_digit:   4'd0,
        tenth_digit:   4'd0,
        all_same:      1'b1,
        saw_non_digit: 1'b0
    };

    // Remainder mod 11 of a value below 128, by a reciprocal multiply.
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 16'(x) * 16'd373;
        q    = prod[15:12];
        r    = x - 7'(q) * 7'd11;
        return r[3:0];
    endfunction

    // Check digit (10 * sum) mod 11 with ten taken as zero, from sum mod 11.
    function automatic logic [3:0] check_digit(input logic [3:0] rem);
        logic [3:0] c;
        if (rem <= 4'd1)
        begin
            c = 4'd0;
        end
        else
        begin
            c = 4'd11 - rem;
        end
        return c;
    endfunction

endpackage

// ----- sv/cdv_core.sv -----
// Next-state and result logic for one character of the identity number.
// Depends on cdv_pkg for the word, state and error code definitions.
module cdv_core
(
    input  cdv_pkg::in_word_t  word,
    input  cdv_pkg::state_t    state,
    output cdv_pkg::state_t    state_next,
    output cdv_pkg::out_word_t result
);

    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] idx;
    logic [3:0] w1;
    logic [3:0] w2;
    logic [7:0] prod1;
    logic [7:0] prod2;
    cdv_pkg::state_t upd;
    logic [2:0] code;

    assign idx      = state.char_count;
    assign is_digit = (word.character >= cdv_pkg::ASCII_ZERO) &&
                      (word.character <= cdv_pkg::ASCII_NINE);
    assign digit    = is_digit ? 4'(word.character - cdv_pkg::ASCII_ZERO) : 4'd0;
    assign w1       = cdv_pkg::FIRST_TOP - idx;
    assign w2       = cdv_pkg::SECOND_TOP - idx;
    assign prod1    = {4'd0, digit} * {4'd0, w1};
    assign prod2    = {4'd0, digit} * {4'd0, w2};

    always_comb
    begin
        upd = state;
        if (!is_digit)
        begin
            upd.saw_non_digit = 1'b1;
        end
        else if (idx < cdv_pkg::NUM_LENGTH)
        begin
            if (idx < cdv_pkg::FIRST_SPAN)
            begin
                upd.first_rem = cdv_pkg::mod11(7'(prod1) + 7'(state.first_rem));
            end
            if (idx < cdv_pkg::SECOND_SPAN)
            begin
                upd.second_rem = cdv_pkg::mod11(7'(prod2) + 7'(state.second_rem));
            end
            if (idx == 4'd0)
            begin
                upd.first_digit = digit;
            end
            else if (digit != state.first_digit)
            begin
                upd.all_same = 1'b0;
            end
            if (idx == cdv_pkg::TENTH_IDX)
            begin
                upd.tenth_digit = digit;
            end
        end
        if (state.char_count < cdv_pkg::COUNT_MAX)
        begin
            upd.char_count = state.char_count + 4'd1;
        end

        if (upd.char_count != cdv_pkg::NUM_LENGTH)
        begin
            code = cdv_pkg::ERR_LENGTH;
        end
        else if (upd.saw_non_digit)
        begin
            code = cdv_pkg::ERR_NON_DIGIT;
        end
        else if (upd.all_same)
        begin
            code = cdv_pkg::ERR_ALL_EQUAL;
        end
        else if (cdv_pkg::check_digit(upd.first_rem) != upd.tenth_digit)
        begin
            code = cdv_pkg::ERR_FIRST;
        end
        else if (cdv_pkg::check_digit(upd.second_rem) != digit)
        begin
            code = cdv_pkg::ERR_SECOND;
        end
        else
        begin
            code = cdv_pkg::ERR_OK;
        end

        result.error_code = code;
        result.valid_res  = (code == cdv_pkg::ERR_OK);
        state_next        = word.last ? cdv_pkg::STATE_RESET : upd;
    end

endmodule

// ----- sv/cpf_check_digit_validator.sv -----
// Top level of the CPF check digit validator: input register, state, result register.
// Depends on cdv_pkg and cdv_core.
//
// An identity number enters one ASCII character per word on the item channel
// (item_valid, item_stall, item_word), with last set on its final character.
// For each number one result word leaves on the res channel (res_valid,
// res_stall, res_word): valid_res and the error code of the first failing
// check (length, non-digit, all digits equal, first or second check digit).
// A word is taken at a rising edge where valid is high and stall is low.
// Each character passes an input register and then one step of mod-11 logic
// into the state and result registers, so the result of a number reaches res_valid
// from the result register. One character is taken every cycle while item_stall
// is low, and a new number may start right after the last one.
// A result waiting in the output register does not stop characters that
// carry no result; only a last character meeting a full, stalled output
// register holds the input side. Reset clears all valid flags and the
// number state, so the next character starts a new number.
module cpf_check_digit_validator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  cdv_pkg::in_word_t   item_word,
    output logic                res_valid,
    input  logic                res_stall,
    output cdv_pkg::out_word_t  res_word
);

    logic               in_vld_reg;
    cdv_pkg::in_word_t  in_reg;
    cdv_pkg::state_t    state_reg;
    cdv_pkg::state_t    state_next;
    logic               out_vld_reg;
    cdv_pkg::out_word_t out_reg;
    cdv_pkg::out_word_t result;
    logic               proceed;

    cdv_core u_core
    (
        .word       (in_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign proceed    = in_vld_reg && (!in_reg.last || !out_vld_reg || !res_stall);
    assign item_stall = in_vld_reg && !proceed;
    assign res_valid  = out_vld_reg;
    assign res_word   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= cdv_pkg::STATE_RESET;
        end
        else
        begin
            if (!item_stall)
            begin
                in_vld_reg <= item_valid;
            end
            if (proceed)
            begin
                state_reg <= state_next;
            end
            if (proceed && in_reg.last)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_reg <= item_word;
        end
        if (proceed && in_reg.last)
        begin
            out_reg <= result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.valid_res == (out_reg.error_code == cdv_pkg::ERR_OK)))
        else $error("valid_res disagrees with the error code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && in_reg.last) |=> (state_reg.char_count == 4'd0 && state_reg.all_same
                                      && !state_reg.saw_non_digit))
        else $error("number state not cleared after a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_vld_reg && in_reg.last && out_vld_reg && res_stall))
        else $error("input held without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.char_count <= cdv_pkg::COUNT_MAX)
        else $error("character count beyond saturation");

endmodule
